// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while the block is out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/pdu_pkg.sv =====
// ----------------------------------------------------------------------------
// PSO dimension update package
// Shared constants, register indexes and stage payload types.
// ----------------------------------------------------------------------------
package pdu_pkg;

    localparam int POS_FRAC_BITS = 16;
    localparam int POS_W         = 32;
    localparam int GAIN_W        = 16;
    localparam int STEP_W        = 24;
    localparam int RAND_W        = 16;
    localparam int RHO_W         = 20;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;

    // Inertia divider: 16 quotient bits, two per stage.
    localparam int WDIV_BITS      = 16;
    localparam int WDIV_PER_STAGE = 2;
    localparam int WDIV_STAGES    = WDIV_BITS / WDIV_PER_STAGE;

    // Wrap remainder: 34 dividend bits, two per stage.
    localparam int WRAP_BITS      = 34;
    localparam int WRAP_PER_STAGE = 2;
    localparam int WRAP_STAGES    = WRAP_BITS / WRAP_PER_STAGE;

    localparam logic [33:0] POS_ONE  = 34'(1) << POS_FRAC_BITS;
    localparam logic [33:0] POS_HALF = 34'(1) << (POS_FRAC_BITS - 1);
    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
    localparam logic signed [55:0] SUM_ROUND = 56'sd32768;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GAIN_PERSONAL = 3'd0,
        REG_GAIN_SOCIAL   = 3'd1,
        REG_INERTIA_MAX   = 3'd2,
        REG_INERTIA_MIN   = 3'd3,
        REG_TOTAL_STEPS   = 3'd4,
        REG_POS_LOW       = 3'd5,
        REG_POS_HIGH      = 3'd6,
        REG_BOUND_FLAGS   = 3'd7
    } t_cfg_reg;

    localparam logic [GAIN_W-1:0] RST_GAIN_PERSONAL = 16'd6128;
    localparam logic [GAIN_W-1:0] RST_GAIN_SOCIAL   = 16'd6128;
    localparam logic [GAIN_W-1:0] RST_INERTIA_MAX   = 16'd2989;
    localparam logic [GAIN_W-1:0] RST_INERTIA_MIN   = 16'd1229;
    localparam logic [STEP_W-1:0] RST_TOTAL_STEPS   = 24'd100000;
    localparam logic [POS_W-1:0]  RST_POS_LOW       = 32'hFFEC_0000;
    localparam logic [POS_W-1:0]  RST_POS_HIGH      = 32'h0014_0000;
    localparam logic [1:0]        RST_BOUND_FLAGS   = 2'd1;

    typedef enum logic [1:0] {
        WM_MAX = 2'd0,
        WM_MIN = 2'd1,
        WM_DIV = 2'd2
    } t_wmode;

    typedef struct packed {
        logic [GAIN_W-1:0]       gain_personal;
        logic [GAIN_W-1:0]       gain_social;
        logic [GAIN_W-1:0]       inertia_max;
        logic [GAIN_W-1:0]       inertia_min;
        logic [STEP_W-1:0]       stage;
        logic signed [POS_W-1:0] pos_low;
        logic signed [POS_W-1:0] pos_high;
        logic                    clamp;
        logic                    round_int;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] velocity;
        logic signed [POS_W-1:0] personal_best;
        logic signed [POS_W-1:0] neighbour_best;
        logic [RAND_W-1:0]       rand_personal;
        logic [RAND_W-1:0]       rand_social;
        logic [STEP_W-1:0]       step_index;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] v;
        logic signed [POS_W-1:0] pb;
        logic signed [POS_W-1:0] nb;
        logic [RHO_W-1:0]        rho1;
        logic [RHO_W-1:0]        rho2;
        logic [GAIN_W-1:0]       w;
    } t_vel_item;

    typedef struct packed {
        logic signed [33:0]      p;
        logic signed [POS_W-1:0] nv;
        logic                    bounded;
        logic                    below;
        logic                    clamp;
        logic [WRAP_BITS-1:0]    dividend;
        logic [POS_W-1:0]        range;
    } t_bnd_item;

    typedef struct packed {
        logic signed [POS_W-1:0] new_position;
        logic signed [POS_W-1:0] new_velocity;
        logic                    was_bounded;
    } t_out_item;

endpackage

// ===== rtl/pdu_weight.sv =====
// ----------------------------------------------------------------------------
// PSO inertia weight pipeline
// Random gains and the linearly falling inertia weight, with a pipelined
// restoring divider for the schedule.
// ----------------------------------------------------------------------------
module pdu_weight (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pdu_pkg::t_cfg      i_cfg,
    input  logic               i_vld,
    output logic               o_rdy,
    input  pdu_pkg::t_in_item  i_item,
    output logic               o_vld,
    input  logic               i_rdy,
    output pdu_pkg::t_vel_item o_item
);

    localparam int NDIV = pdu_pkg::WDIV_STAGES;
    localparam int NS   = NDIV + 3;

    typedef struct packed {
        logic signed [31:0]    x;
        logic signed [31:0]    v;
        logic signed [31:0]    pb;
        logic signed [31:0]    nb;
        logic [19:0]           rho1;
        logic [19:0]           rho2;
        pdu_pkg::t_wmode       mode;
        logic                  neg;
        logic [15:0]           absdiff;
        logic [23:0]           k;
        logic [23:0]           rem;
        logic [15:0]           low;
        logic [15:0]           q;
    } t_wt_pipe;

    // One bit of restoring division; the partial remainder stays below d.
    function automatic t_wt_pipe div_step(t_wt_pipe s, logic [23:0] d);
        t_wt_pipe r;
        logic [24:0] t;
        r = s;
        t = {s.rem, s.low[15]};
        r.low = {s.low[14:0], 1'b0};
        if (t >= {1'b0, d}) begin
            r.rem = 24'(t - {1'b0, d});
            r.q   = {s.q[14:0], 1'b1};
        end else begin
            r.rem = t[23:0];
            r.q   = {s.q[14:0], 1'b0};
        end
        return r;
    endfunction

    logic [NS-1:0]      r_vld;
    logic [NS-1:0]      stage_en;
    t_wt_pipe           r_pipe [NS-1];
    t_wt_pipe           n_pipe [NS-1];
    pdu_pkg::t_vel_item r_out;
    pdu_pkg::t_vel_item n_out;

    logic [31:0]        prod1;
    logic [31:0]        prod2;
    logic signed [16:0] wdiff;
    logic [16:0]        wsum;

    always_comb begin
        stage_en[NS-1] = !r_vld[NS-1] || i_rdy;
        for (int s = NS - 2; s >= 0; s--) begin
            stage_en[s] = !r_vld[s] || stage_en[s+1];
        end
    end

    always_comb begin
        prod1 = i_cfg.gain_personal * i_item.rand_personal;
        prod2 = i_cfg.gain_social * i_item.rand_social;
        wdiff = $signed({1'b0, i_cfg.inertia_max}) - $signed({1'b0, i_cfg.inertia_min});

        n_pipe[0]         = '0;
        n_pipe[0].x       = i_item.position;
        n_pipe[0].v       = i_item.velocity;
        n_pipe[0].pb      = i_item.personal_best;
        n_pipe[0].nb      = i_item.neighbour_best;
        n_pipe[0].rho1    = prod1[31:12];
        n_pipe[0].rho2    = prod2[31:12];
        n_pipe[0].neg     = wdiff[16];
        n_pipe[0].absdiff = wdiff[16] ? 16'(-wdiff) : wdiff[15:0];
        n_pipe[0].k       = i_cfg.stage - i_item.step_index;
        priority if (i_cfg.stage == '0) begin
            n_pipe[0].mode = pdu_pkg::WM_MAX;
        end else if (i_item.step_index > i_cfg.stage) begin
            n_pipe[0].mode = pdu_pkg::WM_MIN;
        end else begin
            n_pipe[0].mode = pdu_pkg::WM_DIV;
        end

        // Full numerator: the top 24 bits already sit below the divisor.
        n_pipe[1] = r_pipe[0];
        {n_pipe[1].rem, n_pipe[1].low} = r_pipe[0].absdiff * r_pipe[0].k;
        n_pipe[1].q = '0;

        for (int s = 2; s < NS - 1; s++) begin
            n_pipe[s] = r_pipe[s-1];
            for (int b = 0; b < pdu_pkg::WDIV_PER_STAGE; b++) begin
                n_pipe[s] = div_step(n_pipe[s], i_cfg.stage);
            end
        end

        if (r_pipe[NS-2].neg) begin
            wsum = {1'b0, i_cfg.inertia_min} - {1'b0, r_pipe[NS-2].q};
        end else begin
            wsum = {1'b0, i_cfg.inertia_min} + {1'b0, r_pipe[NS-2].q};
        end
        n_out.x    = r_pipe[NS-2].x;
        n_out.v    = r_pipe[NS-2].v;
        n_out.pb   = r_pipe[NS-2].pb;
        n_out.nb   = r_pipe[NS-2].nb;
        n_out.rho1 = r_pipe[NS-2].rho1;
        n_out.rho2 = r_pipe[NS-2].rho2;
        unique case (r_pipe[NS-2].mode)
            pdu_pkg::WM_MAX: n_out.w = i_cfg.inertia_max;
            pdu_pkg::WM_MIN: n_out.w = i_cfg.inertia_min;
            pdu_pkg::WM_DIV: n_out.w = wsum[15:0];
            default:         n_out.w = i_cfg.inertia_min;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int s = 1; s < NS; s++) begin
                if (stage_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NS - 1; s++) begin
            if (stage_en[s]) begin
                r_pipe[s] <= n_pipe[s];
            end
        end
        if (stage_en[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_rdy  = stage_en[0];
    assign o_vld  = r_vld[NS-1];
    assign o_item = r_out;

endmodule

// ===== rtl/pdu_velocity.sv =====
// ----------------------------------------------------------------------------
// PSO velocity and position pipeline
// Velocity sum, rounding and saturation, new position, integer rounding and
// bound tests.
// ----------------------------------------------------------------------------
module pdu_velocity (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pdu_pkg::t_cfg      i_cfg,
    input  logic               i_vld,
    output logic               o_rdy,
    input  pdu_pkg::t_vel_item i_item,
    output logic               o_vld,
    input  logic               i_rdy,
    output pdu_pkg::t_bnd_item o_item
);

    localparam int NS = 7;
    localparam int F  = pdu_pkg::POS_FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] v;
        logic [15:0]        w;
        logic [19:0]        rho1;
        logic [19:0]        rho2;
        logic signed [32:0] dp;
        logic signed [32:0] dn;
        logic signed [52:0] pw;
        logic signed [53:0] p1;
        logic signed [53:0] p2;
        logic signed [55:0] sum;
        logic signed [39:0] sh;
        logic signed [31:0] nv;
        logic signed [33:0] p;
    } t_vl_pipe;

    logic [NS-1:0]      r_vld;
    logic [NS-1:0]      stage_en;
    t_vl_pipe           r_pipe [NS-1];
    t_vl_pipe           n_pipe [NS-1];
    pdu_pkg::t_bnd_item r_out;
    pdu_pkg::t_bnd_item n_out;

    logic signed [48:0] mul_w;
    logic signed [53:0] mul_1;
    logic signed [53:0] mul_2;
    logic signed [55:0] sum_r;
    logic signed [31:0] nv_sat;
    logic [33:0]        p_floor;
    logic [F-1:0]       p_frac;
    logic signed [33:0] lo_x;
    logic signed [33:0] hi_x;
    logic signed [32:0] range_x;
    logic               below;
    logic               above;

    always_comb begin
        stage_en[NS-1] = !r_vld[NS-1] || i_rdy;
        for (int s = NS - 2; s >= 0; s--) begin
            stage_en[s] = !r_vld[s] || stage_en[s+1];
        end
    end

    always_comb begin
        n_pipe[0]      = '0;
        n_pipe[0].x    = i_item.x;
        n_pipe[0].v    = i_item.v;
        n_pipe[0].w    = i_item.w;
        n_pipe[0].rho1 = i_item.rho1;
        n_pipe[0].rho2 = i_item.rho2;
        n_pipe[0].dp   = $signed({i_item.pb[31], i_item.pb}) - $signed({i_item.x[31], i_item.x});
        n_pipe[0].dn   = $signed({i_item.nb[31], i_item.nb}) - $signed({i_item.x[31], i_item.x});

        // Products of the velocity sum, all with F+16 fraction bits.
        mul_w = $signed({1'b0, r_pipe[0].w}) * $signed(r_pipe[0].v);
        mul_1 = $signed({1'b0, r_pipe[0].rho1}) * $signed(r_pipe[0].dp);
        mul_2 = $signed({1'b0, r_pipe[0].rho2}) * $signed(r_pipe[0].dn);
        n_pipe[1]    = r_pipe[0];
        n_pipe[1].pw = {mul_w, 4'b0000};
        n_pipe[1].p1 = mul_1;
        n_pipe[1].p2 = mul_2;

        n_pipe[2]     = r_pipe[1];
        n_pipe[2].sum = $signed(r_pipe[1].pw) + $signed(r_pipe[1].p1) + $signed(r_pipe[1].p2);

        // Round half up, then drop 16 bits towards minus infinity.
        sum_r        = $signed(r_pipe[2].sum) + pdu_pkg::SUM_ROUND;
        n_pipe[3]    = r_pipe[2];
        n_pipe[3].sh = sum_r[55:16];

        if (!r_pipe[3].sh[39] && (r_pipe[3].sh[38:31] != '0)) begin
            nv_sat = pdu_pkg::POS_MAX;
        end else if (r_pipe[3].sh[39] && (r_pipe[3].sh[38:31] != '1)) begin
            nv_sat = pdu_pkg::POS_MIN;
        end else begin
            nv_sat = r_pipe[3].sh[31:0];
        end
        n_pipe[4]    = r_pipe[3];
        n_pipe[4].nv = nv_sat;
        n_pipe[4].p  = $signed({{2{nv_sat[31]}}, nv_sat})
                     + $signed({{2{r_pipe[3].x[31]}}, r_pipe[3].x});

        // Round to nearest integer; an exact half goes down.
        p_floor   = {r_pipe[4].p[33:F], {F{1'b0}}};
        p_frac    = r_pipe[4].p[F-1:0];
        n_pipe[5] = r_pipe[4];
        if (i_cfg.round_int) begin
            if (p_frac > pdu_pkg::POS_HALF[F-1:0]) begin
                n_pipe[5].p = p_floor + pdu_pkg::POS_ONE;
            end else begin
                n_pipe[5].p = p_floor;
            end
        end

        lo_x    = {{2{i_cfg.pos_low[31]}}, i_cfg.pos_low};
        hi_x    = {{2{i_cfg.pos_high[31]}}, i_cfg.pos_high};
        range_x = $signed({i_cfg.pos_high[31], i_cfg.pos_high})
                - $signed({i_cfg.pos_low[31], i_cfg.pos_low});
        below   = $signed(r_pipe[5].p) < lo_x;
        above   = $signed(r_pipe[5].p) > hi_x;
        n_out.p       = r_pipe[5].p;
        n_out.nv      = r_pipe[5].nv;
        n_out.below   = below;
        n_out.bounded = below || above;
        n_out.clamp   = i_cfg.clamp || range_x[32] || (range_x == '0);
        n_out.range   = range_x[31:0];
        if (below) begin
            n_out.dividend = lo_x - r_pipe[5].p;
        end else begin
            n_out.dividend = r_pipe[5].p - hi_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int s = 1; s < NS; s++) begin
                if (stage_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NS - 1; s++) begin
            if (stage_en[s]) begin
                r_pipe[s] <= n_pipe[s];
            end
        end
        if (stage_en[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_rdy  = stage_en[0];
    assign o_vld  = r_vld[NS-1];
    assign o_item = r_out;

endmodule

// ===== rtl/pdu_wrap.sv =====
// ----------------------------------------------------------------------------
// PSO bound handling pipeline
// Pipelined remainder for wrap mode and the final clamp or wrap selection.
// ----------------------------------------------------------------------------
module pdu_wrap (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pdu_pkg::t_cfg      i_cfg,
    input  logic               i_vld,
    output logic               o_rdy,
    input  pdu_pkg::t_bnd_item i_item,
    output logic               o_vld,
    input  logic               i_rdy,
    output pdu_pkg::t_out_item o_item
);

    localparam int NDIV = pdu_pkg::WRAP_STAGES;
    localparam int NS   = NDIV + 1;
    localparam int DW   = pdu_pkg::WRAP_BITS;

    typedef struct packed {
        pdu_pkg::t_bnd_item b;
        logic [DW-1:0]      low;
        logic [31:0]        rem;
    } t_wr_pipe;

    function automatic t_wr_pipe rem_step(t_wr_pipe s);
        t_wr_pipe r;
        logic [32:0] t;
        r = s;
        t = {s.rem, s.low[DW-1]};
        r.low = {s.low[DW-2:0], 1'b0};
        if (t >= {1'b0, s.b.range}) begin
            r.rem = 32'(t - {1'b0, s.b.range});
        end else begin
            r.rem = t[31:0];
        end
        return r;
    endfunction

    logic [NS-1:0]      r_vld;
    logic [NS-1:0]      stage_en;
    t_wr_pipe           r_pipe [NDIV];
    t_wr_pipe           n_pipe [NDIV];
    pdu_pkg::t_out_item r_out;
    pdu_pkg::t_out_item n_out;
    t_wr_pipe           last;

    always_comb begin
        stage_en[NS-1] = !r_vld[NS-1] || i_rdy;
        for (int s = NS - 2; s >= 0; s--) begin
            stage_en[s] = !r_vld[s] || stage_en[s+1];
        end
    end

    always_comb begin
        for (int s = 0; s < NDIV; s++) begin
            if (s == 0) begin
                n_pipe[s].b   = i_item;
                n_pipe[s].low = i_item.dividend;
                n_pipe[s].rem = '0;
            end else begin
                n_pipe[s] = r_pipe[s-1];
            end
            for (int b = 0; b < pdu_pkg::WRAP_PER_STAGE; b++) begin
                n_pipe[s] = rem_step(n_pipe[s]);
            end
        end

        last = r_pipe[NDIV-1];
        n_out.was_bounded = last.b.bounded;
        if (!last.b.bounded) begin
            n_out.new_position = last.b.p[31:0];
            n_out.new_velocity = last.b.nv;
        end else begin
            n_out.new_velocity = '0;
            if (last.b.clamp) begin
                n_out.new_position = last.b.below ? i_cfg.pos_low : i_cfg.pos_high;
            end else if (last.b.below) begin
                n_out.new_position = i_cfg.pos_high - last.rem;
            end else begin
                n_out.new_position = i_cfg.pos_low + last.rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int s = 1; s < NS; s++) begin
                if (stage_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NDIV; s++) begin
            if (stage_en[s]) begin
                r_pipe[s] <= n_pipe[s];
            end
        end
        if (stage_en[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_rdy  = stage_en[0];
    assign o_vld  = r_vld[NS-1];
    assign o_item = r_out;

endmodule

// ===== rtl/pso_particle_dimension_update.sv =====
// ----------------------------------------------------------------------------
// PSO particle dimension update
// Velocity and position update of one coordinate of one swarm particle.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries one coordinate: position, velocity,
// personal and neighbourhood best, two random fractions and the step number.
// For every request the master stream returns exactly one result: the new
// position and velocity in tdata and the bounded flag in tuser.
// The datapath is a 36-stage pipeline: 11 stages for the random gains and the
// inertia schedule (its division runs two quotient bits a stage), 7 for the
// velocity sum and position, and 18 for the wrap remainder (two dividend bits
// a stage) and the final bound selection. A new request is taken in every cycle
// while the receiver accepts results.
// Every stage carries a valid bit and only moves when the stage after it is
// free, so when the receiver stalls the pipeline fills up, bubbles are
// squeezed out, and tready falls only once every stage holds a request.
// The configuration port writes one register per cycle with no wait; it is
// to be written only while no request is in flight.
// Synchronous reset empties the pipeline and restores the register defaults.
module pso_particle_dimension_update (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pdu_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [pdu_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // position, velocity, personal_best, neighbour_best, rand_personal,
    // rand_social, step_index (lowest bits first)
    input  logic [183:0]                       i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // new_position, new_velocity (lowest bits first)
    output logic [63:0]                        o_m_axis_tdata,
    // was_bounded
    output logic [0:0]                         o_m_axis_tuser
);

    logic [pdu_pkg::GAIN_W-1:0] r_gain_personal;
    logic [pdu_pkg::GAIN_W-1:0] r_gain_social;
    logic [pdu_pkg::GAIN_W-1:0] r_inertia_max;
    logic [pdu_pkg::GAIN_W-1:0] r_inertia_min;
    logic [pdu_pkg::STEP_W-1:0] r_total_steps;
    logic [pdu_pkg::POS_W-1:0]  r_pos_low;
    logic [pdu_pkg::POS_W-1:0]  r_pos_high;
    logic [1:0]                 r_bound_flags;

    logic [25:0]        steps_x3;
    pdu_pkg::t_cfg      cfg;
    pdu_pkg::t_in_item  in_item;
    pdu_pkg::t_vel_item wt_item;
    pdu_pkg::t_bnd_item vl_item;
    pdu_pkg::t_out_item out_item;
    logic               wt_vld;
    logic               wt_rdy;
    logic               vl_vld;
    logic               vl_rdy;

    // Register file; an address names exactly one register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_personal <= pdu_pkg::RST_GAIN_PERSONAL;
            r_gain_social   <= pdu_pkg::RST_GAIN_SOCIAL;
            r_inertia_max   <= pdu_pkg::RST_INERTIA_MAX;
            r_inertia_min   <= pdu_pkg::RST_INERTIA_MIN;
            r_total_steps   <= pdu_pkg::RST_TOTAL_STEPS;
            r_pos_low       <= pdu_pkg::RST_POS_LOW;
            r_pos_high      <= pdu_pkg::RST_POS_HIGH;
            r_bound_flags   <= pdu_pkg::RST_BOUND_FLAGS;
        end else if (i_cfg_we) begin
            unique case (pdu_pkg::t_cfg_reg'(i_cfg_addr))
                pdu_pkg::REG_GAIN_PERSONAL: r_gain_personal <= i_cfg_wdata[15:0];
                pdu_pkg::REG_GAIN_SOCIAL:   r_gain_social   <= i_cfg_wdata[15:0];
                pdu_pkg::REG_INERTIA_MAX:   r_inertia_max   <= i_cfg_wdata[15:0];
                pdu_pkg::REG_INERTIA_MIN:   r_inertia_min   <= i_cfg_wdata[15:0];
                pdu_pkg::REG_TOTAL_STEPS:   r_total_steps   <= i_cfg_wdata[23:0];
                pdu_pkg::REG_POS_LOW:       r_pos_low       <= i_cfg_wdata;
                pdu_pkg::REG_POS_HIGH:      r_pos_high      <= i_cfg_wdata;
                pdu_pkg::REG_BOUND_FLAGS:   r_bound_flags   <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // The decay stage is three quarters of the planned steps, rounded down.
    assign steps_x3 = {2'b00, r_total_steps} + {1'b0, r_total_steps, 1'b0};

    always_comb begin
        cfg.gain_personal = r_gain_personal;
        cfg.gain_social   = r_gain_social;
        cfg.inertia_max   = r_inertia_max;
        cfg.inertia_min   = r_inertia_min;
        cfg.stage         = steps_x3[25:2];
        cfg.pos_low       = r_pos_low;
        cfg.pos_high      = r_pos_high;
        cfg.clamp         = r_bound_flags[0];
        cfg.round_int     = r_bound_flags[1];

        in_item.position       = i_s_axis_tdata[31:0];
        in_item.velocity       = i_s_axis_tdata[63:32];
        in_item.personal_best  = i_s_axis_tdata[95:64];
        in_item.neighbour_best = i_s_axis_tdata[127:96];
        in_item.rand_personal  = i_s_axis_tdata[143:128];
        in_item.rand_social    = i_s_axis_tdata[159:144];
        in_item.step_index     = i_s_axis_tdata[183:160];
    end

    pdu_weight u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_vld   (i_s_axis_tvalid),
        .o_rdy   (o_s_axis_tready),
        .i_item  (in_item),
        .o_vld   (wt_vld),
        .i_rdy   (wt_rdy),
        .o_item  (wt_item)
    );

    pdu_velocity u_velocity (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_vld   (wt_vld),
        .o_rdy   (wt_rdy),
        .i_item  (wt_item),
        .o_vld   (vl_vld),
        .i_rdy   (vl_rdy),
        .o_item  (vl_item)
    );

    pdu_wrap u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_vld   (vl_vld),
        .o_rdy   (vl_rdy),
        .i_item  (vl_item),
        .o_vld   (o_m_axis_tvalid),
        .i_rdy   (i_m_axis_tready),
        .o_item  (out_item)
    );

    assign o_m_axis_tdata = {out_item.new_velocity, out_item.new_position};
    assign o_m_axis_tuser = out_item.was_bounded;

endmodule

// ===== rtl/pdu_checker.sv =====
// ----------------------------------------------------------------------------
// PSO dimension update port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);

    // An empty pipeline after reset shows no result and takes requests.
    `ASSERT_RST(a_idle_after_reset, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")
    `ASSERT_RST(a_ready_after_reset, !i_rst_n |=> o_s_axis_tready, "not ready after reset")

    // A stalled result must be held unchanged.
    `ASSERT_CLK(a_hold_on_stall, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")

    // A bounded coordinate always leaves with a zero velocity.
    `ASSERT_CLK(a_bounded_stops, o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata[63:32] == 32'd0, "bounded result has velocity")

endmodule

bind pso_particle_dimension_update pdu_checker u_pdu_checker (.*);
